// ===== sv/gprce_pkg.sv =====
// ----------------------------------------------------------------------------
// gprce_pkg
// Shared types, constants and the control store of the report change detector.
// ----------------------------------------------------------------------------
package gprce_pkg;

	localparam int AXIS_DEPTH_C   = 5;
	localparam int BUTTON_BITS_C  = 12;
	localparam int AXIS_BYTES_C   = 5;
	localparam int BUTTON_COUNT_C = 12;

	localparam logic [7:0] AXIS_RESET_C = 8'h0D;
	localparam logic [7:0] HAT_RESET_C  = 8'hDE;

	// event kinds
	localparam logic [1:0] KIND_PAD  = 2'd0;
	localparam logic [1:0] KIND_HAT  = 2'd1;
	localparam logic [1:0] KIND_DOWN = 2'd2;
	localparam logic [1:0] KIND_UP   = 2'd3;

	typedef logic [2:0] pc_t;
	typedef logic [1:0] cond_t;
	typedef logic [1:0] jcond_t;

	// program addresses
	localparam pc_t PC_IDLE = 3'd0;
	localparam pc_t PC_PAD  = 3'd1;
	localparam pc_t PC_HAT  = 3'd2;
	localparam pc_t PC_BTN  = 3'd3;
	localparam pc_t PC_END  = 3'd4;

	// step test
	localparam cond_t C_NEVER = 2'd0;
	localparam cond_t C_PAD   = 2'd1;
	localparam cond_t C_HAT   = 2'd2;
	localparam cond_t C_BIT   = 2'd3;

	// jump condition
	localparam jcond_t J_NEXT   = 2'd0;
	localparam jcond_t J_NOIN   = 2'd1;
	localparam jcond_t J_MORE   = 2'd2;
	localparam jcond_t J_ALWAYS = 2'd3;

	typedef struct packed {
		logic       load;
		cond_t      test;
		logic       emit;
		logic [1:0] kind;
		logic       upd_axes;
		logic       upd_hat;
		logic       upd_btn;
		logic       inc_idx;
		jcond_t     jmp;
		pc_t        target;
	} uop_t;

	function automatic uop_t rom_read(input pc_t pc);
		uop_t u;
		u = '0;
		unique case (pc)
			PC_IDLE: begin
				u.load = 1'b1; u.jmp = J_NOIN; u.target = PC_IDLE;
			end
			PC_PAD: begin
				u.test = C_PAD; u.emit = 1'b1; u.kind = KIND_PAD; u.upd_axes = 1'b1;
			end
			PC_HAT: begin
				u.test = C_HAT; u.emit = 1'b1; u.kind = KIND_HAT; u.upd_hat = 1'b1;
			end
			PC_BTN: begin
				u.test = C_BIT; u.emit = 1'b1; u.kind = KIND_DOWN; u.inc_idx = 1'b1;
				u.jmp = J_MORE; u.target = PC_BTN;
			end
			PC_END: begin
				u.upd_btn = 1'b1; u.jmp = J_ALWAYS; u.target = PC_IDLE;
			end
			default: begin
				u.jmp = J_ALWAYS; u.target = PC_IDLE;
			end
		endcase
		return u;
	endfunction

endpackage

// ===== sv/gamepad_report_change_events_core.sv =====
// ----------------------------------------------------------------------------
// gamepad_report_change_events_core
// Turns gamepad reports into pad, hat and button change events.
// ----------------------------------------------------------------------------
//
// channel   dir  handshake         payload
// s_*       in   tvalid/tready     tdata: x, y, z1, z2, rz, hat+btn1-4, btn5-12
// m_*       out  tvalid/tready     tuser: kind; tdata: code, x..rz; tlast: last
// cfg_*     in   cfg_we            cfg_wdata: handler_attached
//
// A small control store sequences each report: one accept step, one pad step,
// one hat step, BUTTON_COUNT button steps and one closing step, in this order.
// The single output register sets the pace: an emitting step holds while a
// word sits untaken in it. One report is in work at a time; s_tready is high
// only in the accept step. After reset the axis store holds 0x0D, the hat
// store 0xDE (never a valid hat), the button store zero, handler_attached 1.
//
module gamepad_report_change_events_core #(
	parameter int AXIS_BYTES   = gprce_pkg::AXIS_BYTES_C,
	parameter int BUTTON_COUNT = gprce_pkg::BUTTON_COUNT_C
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// axis_x, axis_y, axis_z1, axis_z2, axis_rz, hat_low_buttons, high_buttons
	input  logic [55:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// event_code[3:0], out_x, out_y, out_z1, out_z2, out_rz, 4 zero pad bits
	output logic [47:0] m_tdata,
	// event_kind
	output logic [1:0]  m_tuser,
	// last_event
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_wdata
);
	import gprce_pkg::*;

	localparam int IDX_W = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(BUTTON_COUNT - 1);

	// latched report
	logic [7:0] axes_q [AXIS_DEPTH_C];
	logic [7:0] hatb_q;
	logic [7:0] hib_q;

	// history
	logic [7:0]               prev_axes_q [AXIS_BYTES];
	logic [7:0]               prev_hat_q;
	logic [BUTTON_BITS_C-1:0] prev_btn_q;
	logic                     handler_q;

	// sequencer
	pc_t             pc_q;
	logic [IDX_W-1:0] idx_q;
	uop_t            uop;

	// output word
	logic        m_valid_q;
	logic [1:0]  kind_q;
	logic [3:0]  code_q;
	logic [39:0] oaxes_q;
	logic        last_q;

	logic                     pad_chg, hat_chg, btn_any, btn_rest, more;
	logic [BUTTON_BITS_C-1:0] btn_new, btn_pend;
	logic                     act, slot_free, stall, fire, jump;

	assign btn_new = {hib_q, hatb_q[7:4]};
	assign hat_chg = {4'h0, hatb_q[3:0]} != prev_hat_q;

	always_comb begin
		pad_chg = 1'b0;
		for (int i = 0; i < AXIS_BYTES; i++)
			if (axes_q[i] != prev_axes_q[i])
				pad_chg = 1'b1;
	end

	// only buttons below the count can raise events
	always_comb begin
		btn_rest = 1'b0;
		for (int j = 0; j < BUTTON_BITS_C; j++) begin
			btn_pend[j] = (j < BUTTON_COUNT) ? (btn_new[j] ^ prev_btn_q[j]) : 1'b0;
			if (btn_pend[j] && (j > int'(idx_q)))
				btn_rest = 1'b1;
		end
		btn_any = |btn_pend;
	end

	assign uop = rom_read(pc_q);
	assign more = idx_q != IDX_LAST;

	always_comb begin
		unique case (uop.test)
			C_PAD:   act = handler_q && pad_chg;
			C_HAT:   act = handler_q && hat_chg;
			C_BIT:   act = handler_q && btn_pend[idx_q];
			default: act = 1'b0;
		endcase
		unique case (uop.jmp)
			J_NOIN:  jump = !s_tvalid;
			J_MORE:  jump = more;
			J_ALWAYS: jump = 1'b1;
			default: jump = 1'b0;
		endcase
	end

	assign slot_free = !m_valid_q || m_tready;
	assign stall     = act && uop.emit && !slot_free;
	assign fire      = act && uop.emit && slot_free;
	assign s_tready  = uop.load;

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q      <= PC_IDLE;
			idx_q     <= '0;
			m_valid_q <= 1'b0;
			handler_q <= 1'b1;
			prev_hat_q <= HAT_RESET_C;
			prev_btn_q <= '0;
			for (int i = 0; i < AXIS_BYTES; i++)
				prev_axes_q[i] <= AXIS_RESET_C;
		end else begin
			if (cfg_we)
				handler_q <= cfg_wdata[0];
			if (fire)
				m_valid_q <= 1'b1;
			else if (m_tready)
				m_valid_q <= 1'b0;
			if (!stall) begin
				pc_q <= jump ? uop.target : pc_q + 3'd1;
				if (uop.load)
					idx_q <= '0;
				else if (uop.inc_idx && more)
					idx_q <= idx_q + 1'b1;
				if (act && uop.upd_axes)
					for (int i = 0; i < AXIS_BYTES; i++)
						prev_axes_q[i] <= axes_q[i];
				if (act && uop.upd_hat)
					prev_hat_q <= {4'h0, hatb_q[3:0]};
				if (uop.upd_btn)
					prev_btn_q <= btn_new;
			end
		end
	end

	// report and output payload
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			for (int i = 0; i < AXIS_DEPTH_C; i++)
				axes_q[i] <= s_tdata[8*i +: 8];
			hatb_q <= s_tdata[47:40];
			hib_q  <= s_tdata[55:48];
		end
		if (fire) begin
			oaxes_q <= '0;
			unique case (uop.test)
				C_PAD: begin
					kind_q  <= uop.kind;
					code_q  <= 4'h0;
					oaxes_q <= {axes_q[4], axes_q[3], axes_q[2], axes_q[1], axes_q[0]};
					last_q  <= !hat_chg && !btn_any;
				end
				C_HAT: begin
					kind_q <= uop.kind;
					code_q <= hatb_q[3:0];
					last_q <= !btn_any;
				end
				default: begin
					kind_q <= btn_new[idx_q] ? uop.kind : KIND_UP;
					code_q <= 4'(idx_q) + 4'd1;
					last_q <= !btn_rest;
				end
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = kind_q;
	assign m_tlast  = last_q;
	assign m_tdata  = {4'h0, oaxes_q, code_q};

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= IDX_LAST) else $error("button index past count");
	a_no_evt_off: assert property (@(posedge clk) disable iff (!arst_n)
		fire |-> handler_q) else $error("event with no handler");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		fire |-> (!m_valid_q || m_tready)) else $error("output word overwritten");
	a_accept_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (pc_q == PC_PAD && idx_q == '0))
		else $error("accept did not start program");

endmodule

// ===== dv/gamepad_report_change_events_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gamepad_report_change_events_core_tb
// Self-checking bench: a directed table and random reports are streamed in, and
// every event word is compared with a behavioral copy of the detector or its directed row.
// ----------------------------------------------------------------------------
module gamepad_report_change_events_core_tb;
	import gprce_pkg::*;

	// how a directed row gets its expectation
	localparam logic [1:0] CHK_MODEL = 2'd0;  // from the predictor
	localparam logic [1:0] CHK_NONE  = 2'd1;  // no event at all
	localparam logic [1:0] CHK_ONE   = 2'd2;  // a single event, typed in the row

	localparam int SETTLE_CYCLES = 24;   // a bit more than one report's sequence
	localparam int HOLD_AT       = 80;   // word count at which the long stall starts
	localparam int HOLD_CYCLES   = 500;
	localparam int PHASES        = 8;
	localparam int PHASE_ITEMS   = 42;

	typedef struct packed {
		logic [7:0] x;
		logic [7:0] y;
		logic [7:0] z1;
		logic [7:0] z2;
		logic [7:0] rz;
		logic [7:0] hb;   // hat in [3:0], buttons 1-4 in [7:4]
		logic [7:0] hi;   // buttons 5-12
	} report_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [3:0] code;
		logic [7:0] x;
		logic [7:0] y;
		logic [7:0] z1;
		logic [7:0] z2;
		logic [7:0] rz;
		logic       last;
	} chg_event_t;

	typedef struct packed {
		logic       attach;
		report_t    rpt;
		logic [1:0] chk;
		logic [1:0] kind;
		logic [3:0] code;
	} dir_row_t;

	// Directed reports. Rows typed in follow the state left by the rows above.
	localparam dir_row_t DIR_TBL [18] = '{
		// reset axes match, hat store holds an invalid hat: hat event only
		'{1'b1, '{8'h0D, 8'h0D, 8'h0D, 8'h0D, 8'h0D, 8'h00, 8'h00}, CHK_ONE, KIND_HAT, 4'd0},
		'{1'b1, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, CHK_ONE, KIND_PAD, 4'd0},
		'{1'b1, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, CHK_NONE, KIND_PAD, 4'd0},
		// everything flips: pad, hat and twelve button downs
		'{1'b1, '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, CHK_MODEL, KIND_PAD, 4'd0},
		'{1'b1, '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, CHK_NONE, KIND_PAD, 4'd0},
		'{1'b1, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, CHK_MODEL, KIND_PAD, 4'd0},
		'{1'b1, '{8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, CHK_ONE, KIND_PAD, 4'd0},
		'{1'b1, '{8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h08, 8'h00}, CHK_ONE, KIND_HAT, 4'd8},
		'{1'b1, '{8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h18, 8'h00}, CHK_ONE, KIND_DOWN, 4'd1},
		'{1'b1, '{8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h18, 8'h80}, CHK_ONE, KIND_DOWN, 4'd12},
		'{1'b1, '{8'hA5, 8'h5A, 8'h3C, 8'hC3, 8'h81, 8'h7E, 8'h29}, CHK_MODEL, KIND_PAD, 4'd0},
		// detached: silent, only the button store follows the reports
		'{1'b0, '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, CHK_NONE, KIND_PAD, 4'd0},
		'{1'b0, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, CHK_NONE, KIND_PAD, 4'd0},
		'{1'b0, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h50, 8'h00}, CHK_NONE, KIND_PAD, 4'd0},
		// reattached: axes and hat kept from before the detach, buttons did not
		'{1'b1, '{8'hA5, 8'h5A, 8'h3C, 8'hC3, 8'h81, 8'h7E, 8'h29}, CHK_MODEL, KIND_PAD, 4'd0},
		'{1'b1, '{8'h80, 8'h7F, 8'h01, 8'hFE, 8'h40, 8'hF0, 8'h55}, CHK_MODEL, KIND_PAD, 4'd0},
		'{1'b1, '{8'h80, 8'h7F, 8'h01, 8'hFE, 8'h41, 8'hF0, 8'h55}, CHK_ONE, KIND_PAD, 4'd0},
		'{1'b1, '{8'h80, 8'h7F, 8'h01, 8'hFE, 8'h41, 8'h0F, 8'h55}, CHK_MODEL, KIND_PAD, 4'd0}
	};

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [55:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;
	logic        cfg_we;
	logic [0:0]  cfg_wdata;

	gamepad_report_change_events_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// ---------------------------------------------------------------- predictor
	logic [7:0]  mem_axes [AXIS_DEPTH_C] = '{default: AXIS_RESET_C};
	logic [7:0]  mem_hat  = HAT_RESET_C;
	logic [11:0] mem_btns = '0;
	logic        attached = 1'b1;

	chg_event_t  pred_events [AXIS_DEPTH_C + BUTTON_BITS_C];
	chg_event_t  pending_events [$];
	int unsigned fail_count = 0;
	bit          src_steady = 1'b0;

	// Events one report causes, in emit order; updates the stores.
	function automatic int predict_report(input report_t r);
		logic [7:0]  cur [AXIS_DEPTH_C];
		logic [11:0] btns;
		logic [11:0] flips;
		logic        pad_chg;
		int          n;
		cur     = '{r.x, r.y, r.z1, r.z2, r.rz};
		btns    = {r.hi, r.hb[7:4]};
		flips   = btns ^ mem_btns;
		pad_chg = 1'b0;
		n       = 0;
		for (int i = 0; i < AXIS_BYTES_C; i++)
			if (cur[i] != mem_axes[i])
				pad_chg = 1'b1;
		if (attached) begin
			if (pad_chg) begin
				pred_events[n] = '{KIND_PAD, 4'd0, r.x, r.y, r.z1, r.z2, r.rz, 1'b0};
				n++;
				for (int i = 0; i < AXIS_BYTES_C; i++)
					mem_axes[i] = cur[i];
			end
			if ({4'h0, r.hb[3:0]} != mem_hat) begin
				pred_events[n] = '{KIND_HAT, r.hb[3:0], 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0};
				n++;
				mem_hat = {4'h0, r.hb[3:0]};
			end
			for (int i = 0; i < BUTTON_COUNT_C; i++)
				if (flips[i]) begin
					pred_events[n] = '{btns[i] ? KIND_DOWN : KIND_UP, 4'(i + 1),
						8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0};
					n++;
				end
		end
		mem_btns = btns;   // button store follows even when detached
		if (n > 0)
			pred_events[n - 1].last = 1'b1;
		return n;
	endfunction

	// ---------------------------------------------------------------- sender
	// Offers one report and returns at the edge that accepts it.
	task automatic send_report(input report_t r);
		int unsigned gap;
		gap = src_steady ? 0 : $urandom_range(0, 3);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {r.hi, r.hb, r.rz, r.z2, r.z1, r.y, r.x};
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	// Stop offering, let every expected word drain, then let the sequencer
	// finish its closing step (a silent report may still be in work).
	task automatic quiesce();
		s_tvalid <= 1'b0;
		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_attach(input logic v);
		quiesce();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		attached   = v;
	endtask

	// ---------------------------------------------------------------- receiver
	// Random per-word wait, a stretch of no waits every third block of 50
	// words, and one long stall while the sender keeps offering.
	int unsigned sink_wait;
	int unsigned sink_hold;
	int unsigned words_taken;
	logic        held_once;

	always @(posedge clk or negedge arst_n) begin : sink_ctl
		int unsigned w;
		if (!arst_n) begin
			m_tready    <= 1'b0;
			sink_wait   <= 0;
			sink_hold   <= 0;
			words_taken <= 0;
			held_once   <= 1'b0;
		end else if (sink_hold != 0) begin
			sink_hold <= sink_hold - 1;
		end else if (m_tvalid && m_tready) begin
			words_taken <= words_taken + 1;
			if (!held_once && words_taken == HOLD_AT) begin
				held_once <= 1'b1;
				sink_hold <= HOLD_CYCLES;
				sink_wait <= 0;
				m_tready  <= 1'b0;
			end else begin
				w = ((words_taken / 50) % 3 == 0) ? 0 : $urandom_range(0, 3);
				sink_wait <= w;
				m_tready  <= (w == 0);
			end
		end else if (!m_tready) begin
			if (sink_wait <= 1)
				m_tready <= 1'b1;
			else
				sink_wait <= sink_wait - 1;
		end
	end

	// ---------------------------------------------------------------- checker
	function automatic void cmp_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin : event_check
		chg_event_t ex;
		if (arst_n === 1'b1 && m_tvalid && m_tready) begin
			if (pending_events.size() == 0) begin
				$error("event word with nothing expected: kind %0d code %0d",
					m_tuser, m_tdata[3:0]);
				fail_count++;
			end else begin
				ex = pending_events.pop_front();
				cmp_field("event_kind", ex.kind, m_tuser);
				cmp_field("event_code", ex.code, m_tdata[3:0]);
				cmp_field("out_x", ex.x, m_tdata[11:4]);
				cmp_field("out_y", ex.y, m_tdata[19:12]);
				cmp_field("out_z1", ex.z1, m_tdata[27:20]);
				cmp_field("out_z2", ex.z2, m_tdata[35:28]);
				cmp_field("out_rz", ex.rz, m_tdata[43:36]);
				cmp_field("last_event", ex.last, m_tlast);
			end
		end
	end

	// ---------------------------------------------------------------- stimulus
	initial begin : stim
		report_t     r;
		int          n;
		int unsigned mode;
		int unsigned b;
		logic [7:0]  axv;
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		cfg_we    <= 1'b0;
		cfg_wdata <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_attach(1'b1);

		// directed table
		foreach (DIR_TBL[i]) begin
			if (DIR_TBL[i].attach != attached)
				write_attach(DIR_TBL[i].attach);
			r = DIR_TBL[i].rpt;
			send_report(r);
			n = predict_report(r);
			if (DIR_TBL[i].chk == CHK_MODEL) begin
				for (int k = 0; k < n; k++)
					pending_events.push_back(pred_events[k]);
			end else if (DIR_TBL[i].chk == CHK_ONE) begin
				if (DIR_TBL[i].kind == KIND_PAD)
					pending_events.push_back('{KIND_PAD, 4'd0,
						r.x, r.y, r.z1, r.z2, r.rz, 1'b1});
				else
					pending_events.push_back('{DIR_TBL[i].kind, DIR_TBL[i].code,
						8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1});
			end
		end

		// random phases; mostly small edits of the last report so most reports
		// cause a few events, with full rewrites and exact repeats mixed in
		for (int p = 0; p < PHASES; p++) begin
			write_attach((p == 2 || p == 5) ? 1'b0 : 1'b1);
			src_steady = (p % 3 == 1);
			for (int j = 0; j < PHASE_ITEMS; j++) begin
				mode = $urandom_range(0, 9);
				if (mode < 2) begin
					r.x  = 8'($urandom);
					r.y  = 8'($urandom);
					r.z1 = 8'($urandom);
					r.z2 = 8'($urandom);
					r.rz = 8'($urandom);
					r.hb = 8'($urandom);
					r.hi = 8'($urandom);
				end else if (mode >= 4) begin
					if ($urandom_range(0, 2) == 0) begin
						case ($urandom_range(0, 2))
							0: axv = 8'h00;
							1: axv = 8'hFF;
							default: axv = 8'($urandom);
						endcase
						case ($urandom_range(0, 4))
							0: r.x = axv;
							1: r.y = axv;
							2: r.z1 = axv;
							3: r.z2 = axv;
							default: r.rz = axv;
						endcase
					end
					if ($urandom_range(0, 3) == 0)
						r.hb[3:0] = 4'($urandom);
					repeat ($urandom_range(0, 3)) begin
						b = $urandom_range(0, BUTTON_BITS_C - 1);
						if (b < 4)
							r.hb[4 + b] = ~r.hb[4 + b];
						else
							r.hi[b - 4] = ~r.hi[b - 4];
					end
				end
				send_report(r);
				n = predict_report(r);
				for (int k = 0; k < n; k++)
					pending_events.push_back(pred_events[k]);
			end
		end

		quiesce();
		if (fail_count == 0)
			$display("gamepad_report_change_events_core test passed");
		else
			$display("gamepad_report_change_events_core test failed");
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("gamepad_report_change_events_core test failed");
		$finish;
	end

endmodule
